### rtl/xcfr_pkg.sv
// Shared types and constants of the XOR-checked frame receiver.
package xcfr_pkg;

  localparam logic [7:0] MARKER = 8'hF5;

  // Status codes reported with every received byte.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SKIP      = 3'd1;
  localparam logic [2:0] ST_CMD       = 3'd2;
  localparam logic [2:0] ST_FIELD     = 3'd3;
  localparam logic [2:0] ST_CHECK     = 3'd4;
  localparam logic [2:0] ST_CHECK_ERR = 3'd5;
  localparam logic [2:0] ST_TAIL_ERR  = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CMD_CURRENT = 2'd0;
  localparam logic [1:0] CFG_CMD_BY_ID   = 2'd1;
  localparam logic [1:0] CFG_ACK_OK      = 2'd2;
  localparam logic [1:0] CFG_ACK_LATE    = 2'd3;

  typedef struct packed {
    logic [7:0] cmd_current;
    logic [7:0] cmd_by_id;
    logic [7:0] ack_ok;
    logic [7:0] ack_late;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        in_data_mode;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_ack;
    logic [15:0] frame_word;
    logic        data_opened;
  } result_t;

endpackage

### rtl/xcfr_in_stage.sv
// Input register of the frame receiver: holds one received byte.
module xcfr_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### rtl/xcfr_parser.sv
// Frame parser state machine with its combinational per-byte result.
module xcfr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  xcfr_pkg::cfg_t   cfg_i,
  output xcfr_pkg::result_t res_o
);
  import xcfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_CMD   = 3'd1,
    PH_PARA  = 3'd2,
    PH_CHECK = 3'd3,
    PH_TAIL  = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        data_mode_q, data_mode_d;
  logic [16:0] cnt_q, cnt_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [7:0]  ack_q, ack_d;
  logic [7:0]  last_cmd_q, last_cmd_d;
  logic [7:0]  last_ack_q, last_ack_d;
  logic [15:0] data_len_q, data_len_d;

  logic [16:0] cnt_inc;
  logic        cmd_match;
  logic        ack_match;
  result_t     res;

  assign cnt_inc   = cnt_q + 17'd1;
  assign cmd_match = (cmd_q == cfg_i.cmd_current) || (cmd_q == cfg_i.cmd_by_id);
  assign ack_match = (ack_q == cfg_i.ack_ok) || (ack_q == cfg_i.ack_late);

  always_comb begin
    phase_d     = phase_q;
    data_mode_d = data_mode_q;
    cnt_d       = cnt_q;
    xor_d       = xor_q;
    chk_d       = chk_q;
    cmd_d       = cmd_q;
    len_hi_d    = len_hi_q;
    len_lo_d    = len_lo_q;
    ack_d       = ack_q;
    last_cmd_d  = last_cmd_q;
    last_ack_d  = last_ack_q;
    data_len_d  = data_len_q;

    res               = '0;
    res.status        = ST_SKIP;
    res.in_data_mode  = data_mode_q;

    if (!data_mode_q) begin
      unique case (phase_q)
        PH_HEAD: begin
          if (rx_byte_i == MARKER) begin
            cnt_d   = 17'd1;
            xor_d   = '0;
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_d      = rx_byte_i;
          xor_d      = xor_q ^ rx_byte_i;
          cnt_d      = 17'd2;
          phase_d    = PH_PARA;
          res.status = ST_CMD;
        end
        PH_PARA: begin
          // Field slots: length high, length low, ack, then a spare byte.
          if (cnt_q == 17'd2) len_hi_d = rx_byte_i;
          if (cnt_q == 17'd3) len_lo_d = rx_byte_i;
          if (cnt_q == 17'd4) ack_d    = rx_byte_i;
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = cnt_inc;
          if (cnt_inc >= 17'd6) phase_d = PH_CHECK;
          res.status = ST_FIELD;
        end
        PH_CHECK: begin
          chk_d      = rx_byte_i;
          cnt_d      = cnt_inc;
          phase_d    = PH_TAIL;
          res.status = ST_CHECK;
        end
        PH_TAIL: begin
          if (rx_byte_i == MARKER) begin
            if (xor_q == chk_q) begin
              last_cmd_d     = cmd_q;
              last_ack_d     = ack_q;
              res.frame_word = {len_hi_q, len_lo_q};
              if (cmd_match && ack_match) begin
                data_len_d      = {len_hi_q, len_lo_q};
                data_mode_d     = 1'b1;
                res.data_opened = 1'b1;
              end
              res.status = ST_OK;
            end else begin
              res.status = ST_CHECK_ERR;
            end
          end else begin
            res.status = ST_TAIL_ERR;
          end
          phase_d = PH_HEAD;
          cnt_d   = '0;
        end
        default: begin
          data_mode_d = 1'b0;
          phase_d     = PH_HEAD;
          cnt_d       = '0;
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_HEAD: begin
          if (rx_byte_i == MARKER) begin
            cnt_d   = 17'd1;
            xor_d   = '0;
            phase_d = (data_len_q != '0) ? PH_DATA : PH_CHECK;
          end
        end
        PH_DATA: begin
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = cnt_inc;
          if (cnt_inc == ({1'b0, data_len_q} + 17'd1)) phase_d = PH_CHECK;
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte_i;
          res.status        = ST_FIELD;
        end
        PH_CHECK: begin
          chk_d      = rx_byte_i;
          cnt_d      = cnt_inc;
          phase_d    = PH_TAIL;
          res.status = ST_CHECK;
        end
        PH_TAIL: begin
          if (rx_byte_i == MARKER) begin
            if (xor_q == chk_q) begin
              data_mode_d = 1'b0;
              res.status  = ST_OK;
            end else begin
              res.status  = ST_CHECK_ERR;
            end
          end else begin
            data_mode_d = 1'b0;
            res.status  = ST_TAIL_ERR;
          end
          phase_d = PH_HEAD;
          cnt_d   = '0;
        end
        default: begin
          data_mode_d = 1'b0;
          phase_d     = PH_HEAD;
          cnt_d       = '0;
        end
      endcase
    end

    res.frame_cmd = last_cmd_d;
    res.frame_ack = last_ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      data_mode_q <= 1'b0;
      cnt_q       <= '0;
      xor_q       <= '0;
      chk_q       <= '0;
      cmd_q       <= '0;
      len_hi_q    <= '0;
      len_lo_q    <= '0;
      ack_q       <= '0;
      last_cmd_q  <= '0;
      last_ack_q  <= '0;
      data_len_q  <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      data_mode_q <= data_mode_d;
      cnt_q       <= cnt_d;
      xor_q       <= xor_d;
      chk_q       <= chk_d;
      cmd_q       <= cmd_d;
      len_hi_q    <= len_hi_d;
      len_lo_q    <= len_lo_d;
      ack_q       <= ack_d;
      last_cmd_q  <= last_cmd_d;
      last_ack_q  <= last_ack_d;
      data_len_q  <= data_len_d;
    end
  end

  assign res_o = res;

endmodule

### rtl/xcfr_out_stage.sv
// Result register of the frame receiver with its valid flag.
module xcfr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              valid_i,
  input  xcfr_pkg::result_t res_i,
  output logic              valid_o,
  output xcfr_pkg::result_t res_o
);
  import xcfr_pkg::*;

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/xor_checked_frame_receiver_top.sv
// Top level of the XOR-checked frame receiver.
//
// The input channel (in_valid_i, in_stall_o, rx_byte_i) carries one received
// serial byte per transfer. The output channel (out_valid_o, out_stall_i and
// the result fields) returns exactly one result transfer per input byte, in
// order. Results give a status code, the mode the byte was handled in, a
// streamed payload byte in data mode, the command and ack of the last good
// command frame, and its word with the result of the byte that closes it.
// An input transfer waits in the input register, then the parser and its
// state update feed the result register. Throughput is one byte per cycle
// while the output is not stalled, set by the state update of the parser
// (running XOR, byte counter and phase).
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and in_stall_o rises in the same cycle; it falls as soon as the
// waiting result is taken. Reset clears both valid flags, returns the parser
// to command mode hunting for the marker, and loads the configuration
// registers with their default codes. Configuration writes through cfg_we_i
// take effect at the next edge and are meant to happen while the block is
// idle.
module xor_checked_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        in_data_mode_o,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  frame_cmd_o,
  output logic [7:0]  frame_ack_o,
  output logic [15:0] frame_word_o,
  output logic        data_opened_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import xcfr_pkg::*;

  cfg_t    cfg_q;
  logic    advance;
  logic    stage_valid;
  logic [7:0] stage_byte;
  result_t parse_res;
  result_t out_res;

  // The pipeline moves whenever the result register is empty or being read.
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cmd_current <= 8'd35;
      cfg_q.cmd_by_id   <= 8'd49;
      cfg_q.ack_ok      <= 8'd0;
      cfg_q.ack_late    <= 8'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CMD_CURRENT: cfg_q.cmd_current <= cfg_data_i;
        CFG_CMD_BY_ID:   cfg_q.cmd_by_id   <= cfg_data_i;
        CFG_ACK_OK:      cfg_q.ack_ok      <= cfg_data_i;
        CFG_ACK_LATE:    cfg_q.ack_late    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  xcfr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  // The parser state steps only when a held byte moves into the result register.
  xcfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance && stage_valid),
    .rx_byte_i (stage_byte),
    .cfg_i     (cfg_q),
    .res_o     (parse_res)
  );

  xcfr_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (stage_valid),
    .res_i     (parse_res),
    .valid_o   (out_valid_o),
    .res_o     (out_res)
  );

  assign status_o        = out_res.status;
  assign in_data_mode_o  = out_res.in_data_mode;
  assign payload_valid_o = out_res.payload_valid;
  assign payload_byte_o  = out_res.payload_byte;
  assign frame_cmd_o     = out_res.frame_cmd;
  assign frame_ack_o     = out_res.frame_ack;
  assign frame_word_o    = out_res.frame_word;
  assign data_opened_o   = out_res.data_opened;

endmodule

### rtl/xcfr_checker.sv
// Port-level checker of the frame receiver and its bind to the top level.
module xcfr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_stall_o,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  status_o,
  input  logic        in_data_mode_o,
  input  logic        payload_valid_o,
  input  logic [7:0]  payload_byte_o,
  input  logic        data_opened_o
);
  import xcfr_pkg::*;

  // The input side stalls exactly when a waiting result is held back.
  a_stall_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not match held result");

  // A payload byte is only ever a data-mode field byte.
  a_payload_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (in_data_mode_o && status_o == ST_FIELD))
    else $error("payload flagged outside data mode");

  // Non-payload results carry a zero payload byte.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (payload_byte_o == 8'd0))
    else $error("payload byte set without payload flag");

  // Data mode opens only on a good command frame.
  a_open_on_good_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_opened_o) |-> (!in_data_mode_o && status_o == ST_OK))
    else $error("data mode opened by a bad frame");

  // A stalled result holds its status.
  a_stalled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind xor_checked_frame_receiver_top xcfr_checker u_xcfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .in_data_mode_o  (in_data_mode_o),
  .payload_valid_o (payload_valid_o),
  .payload_byte_o  (payload_byte_o),
  .data_opened_o   (data_opened_o)
);

### sim/tb_xor_checked_frame_receiver_top.sv
// Self-checking testbench for the XOR-checked frame receiver top level.
import xcfr_pkg::*;

// Parser position, kept by the scoreboard's own model of the receiver.
typedef enum logic [2:0] {
  PH_HUNT, PH_COMMAND, PH_FIELDS, PH_PAYLOAD, PH_CHECK, PH_TAIL
} parse_phase_e;

class frame_scoreboard;
  cfg_t         cfg;
  int unsigned  failures;
  int unsigned  reported;
  result_t      expected_results[$];
  parse_phase_e phase;
  logic         data_mode;
  logic [16:0]  count;
  logic [7:0]   xor_sum;
  logic [7:0]   check_byte;
  logic [7:0]   last_cmd;
  logic [7:0]   last_ack;
  logic [7:0]   fields[5];
  logic [15:0]  data_len;

  function new();
    cfg = '{cmd_current: 8'd35, cmd_by_id: 8'd49, ack_ok: 8'd0, ack_late: 8'd8};
    failures = 0;
    reported = 0;
    phase = PH_HUNT;
    data_mode = 1'b0;
    count = '0;
    xor_sum = '0;
    check_byte = '0;
    last_cmd = '0;
    last_ack = '0;
    data_len = '0;
    foreach (fields[i]) fields[i] = '0;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  // Advances the model by one accepted byte and queues the result it must give.
  function void note_transfer(logic [7:0] b);
    result_t r;
    r = '0;
    r.status = ST_SKIP;
    r.in_data_mode = data_mode;
    if (phase == PH_PAYLOAD ? !data_mode
                            : (data_mode && (phase == PH_COMMAND || phase == PH_FIELDS))) begin
      // A phase that does not belong to the current mode falls back to the hunt.
      data_mode = 1'b0;
      phase = PH_HUNT;
      count = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (b == MARKER) begin
            count = 17'd1;
            xor_sum = '0;
            if (!data_mode) phase = PH_COMMAND;
            else phase = (data_len != 0) ? PH_PAYLOAD : PH_CHECK;
          end
        end
        PH_COMMAND: begin
          fields[0] = b;
          xor_sum ^= b;
          count = 17'd2;
          phase = PH_FIELDS;
          r.status = ST_CMD;
        end
        PH_FIELDS: begin
          if (count >= 2 && count <= 5) fields[count - 17'd1] = b;
          xor_sum ^= b;
          count = count + 17'd1;
          if (count >= 6) phase = PH_CHECK;
          r.status = ST_FIELD;
        end
        PH_PAYLOAD: begin
          xor_sum ^= b;
          count = count + 17'd1;
          if (count == {1'b0, data_len} + 17'd1) phase = PH_CHECK;
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          r.status = ST_FIELD;
        end
        PH_CHECK: begin
          check_byte = b;
          count = count + 17'd1;
          phase = PH_TAIL;
          r.status = ST_CHECK;
        end
        PH_TAIL: begin
          if (b != MARKER) begin
            r.status = ST_TAIL_ERR;
            data_mode = 1'b0;
          end else if (xor_sum != check_byte) begin
            r.status = ST_CHECK_ERR;
          end else begin
            r.status = ST_OK;
            if (r.in_data_mode) begin
              data_mode = 1'b0;
            end else begin
              last_cmd = fields[0];
              last_ack = fields[3];
              r.frame_word = {fields[1], fields[2]};
              if ((fields[0] == cfg.cmd_current || fields[0] == cfg.cmd_by_id) &&
                  (fields[3] == cfg.ack_ok || fields[3] == cfg.ack_late)) begin
                data_len = r.frame_word;
                data_mode = 1'b1;
                r.data_opened = 1'b1;
              end
            end
          end
          phase = PH_HUNT;
          count = '0;
        end
        default: begin
          data_mode = 1'b0;
          phase = PH_HUNT;
          count = '0;
        end
      endcase
    end
    r.frame_cmd = last_cmd;
    r.frame_ack = last_ack;
    expected_results.push_back(r);
  endfunction

  function void compare(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      failures++;
      if (reported < 100) begin
        reported++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      failures++;
      $display("%0t: result %h arrived with no byte waiting for it", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare("status", want.status, got.status);
    compare("in_data_mode", want.in_data_mode, got.in_data_mode);
    compare("payload_valid", want.payload_valid, got.payload_valid);
    compare("payload_byte", want.payload_byte, got.payload_byte);
    compare("frame_cmd", want.frame_cmd, got.frame_cmd);
    compare("frame_ack", want.frame_ack, got.frame_ack);
    compare("frame_word", want.frame_word, got.frame_word);
    compare("data_opened", want.data_opened, got.data_opened);
  endfunction
endclass

module tb_xor_checked_frame_receiver_top;

  // All block inputs start at known values; the clock starts low.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic        in_data_mode_o;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  frame_cmd_o;
  logic [7:0]  frame_ack_o;
  logic [15:0] frame_word_o;
  logic        data_opened_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_CMD_CURRENT;
  logic [7:0]  cfg_data_i = '0;

  frame_scoreboard sb = new();

  // Bytes waiting to be offered to the block, in order.
  logic [7:0] byte_plan[$];

  // Set by the main sequence to ask the receiver side for one long hold-off.
  bit hold_pending = 1'b0;

  xor_checked_frame_receiver_top uut (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({status_o, in_data_mode_o, payload_valid_o, payload_byte_o,
                       frame_cmd_o, frame_ack_o, frame_word_o, data_opened_o});
    end
  end

  // The receiver side alternates free-running stretches with short and long
  // stalls. A requested hold-off stalls long enough that the block fills up
  // and must stall its own input.
  initial begin : pace_receiver
    int unsigned pick;
    int unsigned stretch;
    logic        stall_now;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pick = $urandom_range(0, 99);
      if (hold_pending) begin
        stall_now = 1'b1;
        stretch = 400;
        hold_pending = 1'b0;
      end else if (pick < 50) begin
        stall_now = 1'b0;
        stretch = $urandom_range(1, 40);
      end else if (pick < 92) begin
        stall_now = 1'b1;
        stretch = $urandom_range(1, 3);
      end else begin
        stall_now = 1'b1;
        stretch = $urandom_range(15, 60);
      end
      out_stall_i <= stall_now;
      repeat (stretch - 1) @(negedge clk_i);
    end
  end

  // Mostly back-to-back bytes, some short gaps and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Payload lengths are mostly tiny, with the occasional longer packet.
  function automatic int unsigned pick_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 12);
    if (pick < 97) return $urandom_range(13, 40);
    return $urandom_range(41, 64);
  endfunction

  function automatic logic [7:0] other_than_marker();
    logic [7:0] b;
    do b = 8'($urandom); while (b == MARKER);
    return b;
  endfunction

  // Bytes the parser skips while hunting; they never contain the marker.
  function automatic void push_noise(int unsigned n);
    repeat (n) byte_plan.push_back(other_than_marker());
  endfunction

  // Queues a complete command frame. A nonzero check_flip spoils the check
  // byte; a tail other than the marker spoils the closing byte.
  function automatic int unsigned push_frame(logic [7:0] cmd, logic [15:0] word,
                                             logic [7:0] ack, logic [7:0] spare,
                                             logic [7:0] check_flip, logic [7:0] tail);
    byte_plan.push_back(MARKER);
    byte_plan.push_back(cmd);
    byte_plan.push_back(word[15:8]);
    byte_plan.push_back(word[7:0]);
    byte_plan.push_back(ack);
    byte_plan.push_back(spare);
    byte_plan.push_back(cmd ^ word[15:8] ^ word[7:0] ^ ack ^ spare ^ check_flip);
    byte_plan.push_back(tail);
    return 8;
  endfunction

  // Queues a data packet with random payload of the given length.
  function automatic int unsigned push_packet(int unsigned len, logic [7:0] check_flip,
                                              logic [7:0] tail);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    byte_plan.push_back(MARKER);
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      sum ^= b;
      byte_plan.push_back(b);
    end
    byte_plan.push_back(sum ^ check_flip);
    byte_plan.push_back(tail);
    return len + 3;
  endfunction

  // An opening frame followed by packets until data mode is left again. A
  // checksum error keeps data mode, so another packet of the same length follows.
  function automatic int unsigned plan_session();
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  cmd;
    logic [7:0]  ack;
    bit          still_open;
    cmd = $urandom_range(0, 1) ? sb.cfg.cmd_current : sb.cfg.cmd_by_id;
    ack = $urandom_range(0, 1) ? sb.cfg.ack_ok : sb.cfg.ack_late;
    len = pick_length();
    n = push_frame(cmd, 16'(len), ack, 8'($urandom), 8'd0, MARKER);
    still_open = 1'b1;
    while (still_open) begin
      if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 3));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        n += push_packet(len, 8'($urandom_range(1, 255)), MARKER);
      end else if (pick < 20) begin
        n += push_packet(len, 8'($urandom), other_than_marker());
        still_open = 1'b0;
      end else begin
        n += push_packet(len, 8'd0, MARKER);
        still_open = 1'b0;
      end
    end
    return n;
  endfunction

  // A good frame that must not open data mode, so its word may take any value.
  function automatic int unsigned plan_plain_frame();
    logic [7:0] cmd;
    logic [7:0] ack;
    cmd = $urandom_range(0, 2) == 0 ? sb.cfg.cmd_current : 8'($urandom);
    ack = $urandom_range(0, 2) == 0 ? sb.cfg.ack_ok : 8'($urandom);
    if (cmd == sb.cfg.cmd_current || cmd == sb.cfg.cmd_by_id) begin
      while (ack == sb.cfg.ack_ok || ack == sb.cfg.ack_late) ack = 8'($urandom);
    end
    return push_frame(cmd, 16'($urandom), ack, 8'($urandom), 8'd0, MARKER);
  endfunction

  // A frame with a bad check or a bad tail; nothing may be latched from it.
  function automatic int unsigned plan_broken_frame();
    logic [7:0] cmd;
    cmd = $urandom_range(0, 1) ? sb.cfg.cmd_by_id : 8'($urandom);
    if ($urandom_range(0, 1))
      return push_frame(cmd, 16'($urandom), sb.cfg.ack_late, 8'($urandom),
                        8'($urandom_range(1, 255)), MARKER);
    return push_frame(cmd, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      other_than_marker());
  endfunction

  // Mostly well-formed traffic with random content, plus broken frames and noise.
  // Skipped noise does not count toward the target.
  function automatic void plan_random(int unsigned target);
    int unsigned planned;
    int unsigned pick;
    planned = 0;
    while (planned < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) planned += plan_session();
      else if (pick < 75) planned += plan_plain_frame();
      else if (pick < 90) planned += plan_broken_frame();
      else push_noise($urandom_range(1, 4));
    end
  endfunction

  // Offers every planned byte. Starts and ends at a falling edge; valid and the
  // byte hold still until the block takes the transfer.
  task automatic send_plan(bit no_gaps);
    logic [7:0]  b;
    int unsigned gap;
    while (byte_plan.size() != 0) begin
      b = byte_plan.pop_front();
      gap = no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i <= b;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_transfer(b);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // Waits until every expected result has been taken and the two-stage
  // pipeline has drained.
  task automatic settle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all four registers on consecutive edges; the block is idle here.
  task automatic write_config(cfg_t c);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_CMD_CURRENT;
    cfg_data_i <= c.cmd_current;
    @(negedge clk_i);
    cfg_index_i <= CFG_CMD_BY_ID;
    cfg_data_i <= c.cmd_by_id;
    @(negedge clk_i);
    cfg_index_i <= CFG_ACK_OK;
    cfg_data_i <= c.ack_ok;
    @(negedge clk_i);
    cfg_index_i <= CFG_ACK_LATE;
    cfg_data_i <= c.ack_late;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cfg = c;
  endtask

  initial begin : main_sequence
    int unsigned ignored;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed bytes under the reset codes: skipped bytes at both extremes, an
    // empty data packet whose check follows the marker at once, then a one-byte
    // packet with a checksum error (data mode stays) and one with a tail error
    // (data mode ends).
    push_noise(0);
    byte_plan.push_back(8'h00);
    byte_plan.push_back(8'hFF);
    ignored = push_frame(sb.cfg.cmd_current, 16'h0000, sb.cfg.ack_ok, 8'hFF, 8'd0, MARKER);
    ignored = push_packet(0, 8'd0, MARKER);
    ignored = push_frame(sb.cfg.cmd_by_id, 16'h0001, sb.cfg.ack_late, 8'h00, 8'd0, MARKER);
    ignored = push_packet(1, 8'hFF, MARKER);
    ignored = push_packet(1, 8'd0, 8'h00);
    send_plan(1'b0);

    // Extreme register values.
    settle();
    write_config('{cmd_current: 8'h00, cmd_by_id: 8'hFF, ack_ok: 8'hFF, ack_late: 8'h00});
    plan_random(100);
    send_plan(1'b0);

    // Codes equal to the marker itself, with a random timeout code.
    settle();
    write_config('{cmd_current: MARKER, cmd_by_id: MARKER, ack_ok: MARKER,
                   ack_late: 8'($urandom)});
    plan_random(100);
    send_plan(1'b0);

    // Random codes. The receiver holds off for a long stretch while the sender
    // keeps offering bytes back to back, so the block must stall its input.
    settle();
    write_config('{cmd_current: 8'($urandom), cmd_by_id: 8'($urandom),
                   ack_ok: 8'($urandom), ack_late: 8'($urandom)});
    hold_pending = 1'b1;
    plan_random(100);
    send_plan(1'b1);

    // Back to the reset codes.
    settle();
    write_config('{cmd_current: 8'd35, cmd_by_id: 8'd49, ack_ok: 8'd0, ack_late: 8'd8});
    plan_random(100);
    send_plan(1'b0);

    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Ends a hung run; the bound is far beyond the slowest correct run.
  initial begin : watchdog
    #(12 * 2000000);
    $display("%0t: timed out with %0d results outstanding", $time, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/xcfr_pkg.sv
rtl/xcfr_in_stage.sv
rtl/xcfr_parser.sv
rtl/xcfr_out_stage.sv
rtl/xor_checked_frame_receiver_top.sv
rtl/xcfr_checker.sv
sim/tb_xor_checked_frame_receiver_top.sv
